@@ hw/rtl/sac_pkg.sv @@
// shared types, constants and codes of the segment allocator
package sac_pkg;

  localparam int FREE_ENTRIES = 32;
  localparam int SEGMENT_IDS  = 16;
  localparam int ADDR_BITS    = 16;

  localparam int IDX_W = $clog2(FREE_ENTRIES);
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int ID_W  = $clog2(SEGMENT_IDS);
  localparam int AW    = ADDR_BITS;
  localparam int LW    = ADDR_BITS + 1;
  localparam int EW    = ADDR_BITS + 2;

  localparam logic [LW-1:0] TOTAL_RESET = LW'(1024);
  localparam logic [LW-1:0] TOTAL_MAX   = LW'(1) << ADDR_BITS;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_INUSE   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } extent_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_FETCH,
    DP_STEP,
    DP_CAPT,
    DP_PREV,
    DP_SETUP_UP,
    DP_SETUP_DN,
    DP_SHUP,
    DP_SHDN,
    DP_COMMIT,
    DP_FAIL
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rem;
    logic zero_sz;
    logic id_used;
    logic at_end;
    logic hit;
    logic ge;
    logic full;
    logic bnz;
    logic anz;
    logic mprev;
    logic mnext;
    logic up_done;
    logic dn_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/sac_dp.sv @@
// datapath: free extent table, segment table and request registers
module sac_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sac_pkg::LW-1:0]      cfg_total,
  input  sac_pkg::dp_cmd_t            cmd,
  input  logic                        in_kind,
  input  logic [sac_pkg::ID_W-1:0]    in_id,
  input  logic [sac_pkg::AW-1:0]      in_start,
  input  logic [sac_pkg::LW-1:0]      in_size,
  output sac_pkg::dp_stat_t           stat,
  output logic [2:0]                  res_status,
  output logic [sac_pkg::CNT_W-1:0]   count
);
  import sac_pkg::*;

  extent_t          ftab [FREE_ENTRIES];
  logic             alloc_valid [SEGMENT_IDS];
  logic [AW-1:0]    alloc_start [SEGMENT_IDS];
  logic [LW-1:0]    alloc_len [SEGMENT_IDS];

  logic             r_kind;
  logic [ID_W-1:0]  r_id;
  logic [AW-1:0]    r_st;
  logic [LW-1:0]    r_len;
  logic [EW-1:0]    r_end;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic [LW-1:0]    b_len;
  logic [LW-1:0]    a_len;
  logic [LW-1:0]    nxt_len;
  logic [LW-1:0]    prev_len;
  logic             mnext;
  logic             mprev;

  logic [CNT_W-1:0] ridx;
  extent_t          rd;
  logic [EW-1:0]    rd_end;
  logic [LW-1:0]    tsat;
  logic [CNT_W-1:0] gap;
  logic [CNT_W-1:0] pos_m1;

  always_comb begin
    unique case (cmd.op)
      DP_PREV, DP_SHUP: ridx = idx - CNT_W'(1);
      DP_SHDN:          ridx = idx + CNT_W'(1);
      default:          ridx = idx;
    endcase
  end

  assign rd     = ftab[ridx[IDX_W-1:0]];
  assign rd_end = {2'b00, rd.start} + {1'b0, rd.len};
  assign gap    = r_kind ? pos : pos + CNT_W'(1);
  assign pos_m1 = pos - CNT_W'(1);

  always_comb begin
    if (rst) begin
      tsat = TOTAL_RESET;
    end else if (cfg_total > TOTAL_MAX) begin
      tsat = TOTAL_MAX;
    end else begin
      tsat = cfg_total;
    end
  end

  assign stat.is_rem  = r_kind;
  assign stat.zero_sz = (r_len == '0);
  assign stat.id_used = alloc_valid[r_id];
  assign stat.at_end  = (idx == count);
  assign stat.hit     = (rd.start <= r_st) && (rd_end >= r_end);
  assign stat.ge      = (rd.start >= r_st);
  assign stat.full    = (count == CNT_W'(FREE_ENTRIES));
  assign stat.bnz     = (b_len != '0);
  assign stat.anz     = (a_len != '0);
  assign stat.mprev   = mprev;
  assign stat.mnext   = mnext;
  assign stat.up_done = (idx == gap);
  assign stat.dn_done = ({1'b0, idx} + (CNT_W+1)'(1)) >= {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      count      <= (tsat != '0) ? CNT_W'(1) : '0;
      ftab[0]    <= '{start: '0, len: tsat};
      for (int i = 0; i < SEGMENT_IDS; i++) begin
        alloc_valid[i] <= 1'b0;
      end
      idx        <= '0;
      res_status <= ST_OK;
    end else begin
      unique case (cmd.op)
        DP_LOAD: begin
          r_kind <= in_kind;
          r_id   <= in_id;
          r_st   <= in_start;
          r_len  <= in_size;
          r_end  <= {2'b00, in_start} + {1'b0, in_size};
          idx    <= '0;
        end
        // remove takes its range from the segment table before the scan
        DP_FETCH: begin
          r_st  <= alloc_start[r_id];
          r_len <= alloc_len[r_id];
          r_end <= {2'b00, alloc_start[r_id]} + {1'b0, alloc_len[r_id]};
        end
        DP_STEP: idx <= idx + CNT_W'(1);
        DP_CAPT: begin
          pos     <= idx;
          b_len   <= {1'b0, r_st} - {1'b0, rd.start};
          a_len   <= LW'(rd_end - r_end);
          nxt_len <= rd.len;
          mnext   <= (idx != count) && ({2'b00, rd.start} == r_end);
        end
        DP_PREV: begin
          mprev    <= (pos != '0) && (rd_end == {2'b00, r_st});
          prev_len <= rd.len;
        end
        DP_SETUP_UP: idx <= count;
        DP_SETUP_DN: idx <= pos;
        DP_SHUP: begin
          ftab[idx[IDX_W-1:0]] <= rd;
          idx <= idx - CNT_W'(1);
        end
        DP_SHDN: begin
          ftab[idx[IDX_W-1:0]] <= rd;
          idx <= idx + CNT_W'(1);
        end
        DP_FAIL: res_status <= cmd.code;
        DP_COMMIT: begin
          res_status <= ST_OK;
          if (r_kind == KIND_CREATE) begin
            alloc_valid[r_id] <= 1'b1;
            alloc_start[r_id] <= r_st;
            alloc_len[r_id]   <= r_len;
            if (b_len != '0 && a_len != '0) begin
              ftab[pos[IDX_W-1:0]].len <= b_len;
              ftab[gap[IDX_W-1:0]]     <= '{start: r_end[AW-1:0], len: a_len};
              count <= count + CNT_W'(1);
            end else if (b_len != '0) begin
              ftab[pos[IDX_W-1:0]].len <= b_len;
            end else if (a_len != '0) begin
              ftab[pos[IDX_W-1:0]] <= '{start: r_end[AW-1:0], len: a_len};
            end else begin
              count <= count - CNT_W'(1);
            end
          end else begin
            alloc_valid[r_id] <= 1'b0;
            if (mprev && mnext) begin
              ftab[pos_m1[IDX_W-1:0]].len <= LW'(prev_len + alloc_len[r_id] + nxt_len);
              count <= count - CNT_W'(1);
            end else if (mprev) begin
              ftab[pos_m1[IDX_W-1:0]].len <= LW'(prev_len + alloc_len[r_id]);
            end else if (mnext) begin
              ftab[pos[IDX_W-1:0]] <= '{start: alloc_start[r_id],
                                        len: LW'(nxt_len + alloc_len[r_id])};
            end else begin
              ftab[pos[IDX_W-1:0]] <= '{start: alloc_start[r_id], len: alloc_len[r_id]};
              count <= count + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FREE_ENTRIES))
    else $error("free extent count beyond table size");

  a_no_shift_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SHUP) |-> (count < CNT_W'(FREE_ENTRIES)))
    else $error("gap opened in a full table");

  a_shdn_inside: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SHDN) |-> (idx < count))
    else $error("gap close ran past the last extent");

endmodule

@@ hw/rtl/sac_ctrl.sv @@
// controller state machine sequencing checks, scan, shifts and commit
module sac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  sac_pkg::dp_stat_t stat,
  output sac_pkg::dp_cmd_t  cmd
);
  import sac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_PREV, S_DECIDE, S_UP, S_DN, S_COMMIT, S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    cmd.code   = ST_OK;
    cmd.emit   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_rem) begin
          if (!stat.id_used) begin
            cmd.op = DP_FAIL; cmd.code = ST_UNKNOWN; state_next = S_RESP;
          end else begin
            cmd.op = DP_FETCH; state_next = S_SCAN;
          end
        end else if (stat.zero_sz) begin
          cmd.op = DP_FAIL; cmd.code = ST_NOFIT; state_next = S_RESP;
        end else if (stat.id_used) begin
          cmd.op = DP_FAIL; cmd.code = ST_INUSE; state_next = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.is_rem) begin
          if (stat.at_end || stat.ge) begin
            cmd.op = DP_CAPT; state_next = S_PREV;
          end else begin
            cmd.op = DP_STEP;
          end
        end else if (stat.at_end) begin
          cmd.op = DP_FAIL; cmd.code = ST_NOFIT; state_next = S_RESP;
        end else if (stat.hit) begin
          cmd.op = DP_CAPT; state_next = S_DECIDE;
        end else begin
          cmd.op = DP_STEP;
        end
      end
      S_PREV: begin
        cmd.op = DP_PREV; state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.is_rem) begin
          if (stat.mprev && stat.mnext) begin
            cmd.op = DP_SETUP_DN; state_next = S_DN;
          end else if (!stat.mprev && !stat.mnext) begin
            if (stat.full) begin
              cmd.op = DP_FAIL; cmd.code = ST_FULL; state_next = S_RESP;
            end else begin
              cmd.op = DP_SETUP_UP; state_next = S_UP;
            end
          end else begin
            state_next = S_COMMIT;
          end
        end else if (stat.bnz && stat.anz) begin
          if (stat.full) begin
            cmd.op = DP_FAIL; cmd.code = ST_FULL; state_next = S_RESP;
          end else begin
            cmd.op = DP_SETUP_UP; state_next = S_UP;
          end
        end else if (!stat.bnz && !stat.anz) begin
          cmd.op = DP_SETUP_DN; state_next = S_DN;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_UP: begin
        if (stat.up_done) begin
          state_next = S_COMMIT;
        end else begin
          cmd.op = DP_SHUP;
        end
      end
      S_DN: begin
        if (stat.dn_done) begin
          state_next = S_COMMIT;
        end else begin
          cmd.op = DP_SHDN;
        end
      end
      S_COMMIT: begin
        cmd.op = DP_COMMIT; state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.emit = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/segment_allocator_coalescing.sv @@
// top level of the segment allocator: config register, output stage, controller and datapath
//
// usage
// - request channel s_*: tuser holds the kind (create or remove), tdata the segment
//   id, start word and size; one beat per request
// - response channel m_*: one beat per request with status and the number of free
//   extents left after it
// - config port (apb style): word count at address 0; a write re-initializes the
//   block to one free extent covering all words and no segments; write only when idle
// timing
// - one request at a time; the free extents are stepped over one per cycle through the
//   table's single read port, and table entries may move to open or close a gap
// - the response sits in an output register; a stalled m_tready holds it and the
//   next request waits in the response step until the register frees
// reset
// - synchronous; gives 1024 words, one free extent, no segments, no response
module segment_allocator_coalescing (
  input  logic        clk,
  input  logic        rst,
  // request beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // segment_id[3:0], seg_start[19:4], seg_size[36:20]
  input  logic        s_tuser,   // kind
  // response beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[2:0], free_extents[8:3]
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sac_pkg::*;

  logic [LW-1:0]    mem_words;
  logic             cfg_we;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [2:0]       res_status;
  logic [CNT_W-1:0] count;
  logic             out_free;

  // register write on the access phase, only register 0 exists
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-LW){1'b0}}, mem_words} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_words <= TOTAL_RESET;
    end else if (cfg_we) begin
      mem_words <= pwdata[LW-1:0];
    end
  end

  // output stage frees when empty or when the current beat is taken
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'd0, 6'(count), res_status};
    end
  end

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  sac_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_total  (pwdata[LW-1:0]),
    .cmd        (cmd),
    .in_kind    (s_tuser),
    .in_id      (s_tdata[ID_W-1:0]),
    .in_start   (s_tdata[ID_W+AW-1:ID_W]),
    .in_size    (s_tdata[ID_W+AW+LW-1:ID_W+AW]),
    .stat       (stat),
    .res_status (res_status),
    .count      (count)
  );

endmodule
